/* hw/rtl/retransmit_bitmap_scanner_defines.svh */
// Assertion macros shared by the checker of the retransmit bitmap scanner.
// No dependencies; each macro expands to one concurrent assertion.
`ifndef RETRANSMIT_BITMAP_SCANNER_DEFINES_SVH
`define RETRANSMIT_BITMAP_SCANNER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RBS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rbs assertion failed");

// Next-cycle implication, checked outside reset.
`define RBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rbs assertion failed");

`endif

/* hw/rtl/rbs_pkg.sv */
// Package of the retransmit bitmap scanner: transfer types, request codes,
// register indexes, state codes and fixed widths. No dependencies.
package rbs_pkg;

    // Fixed widths of the fields and of the internal scan position.
    localparam int CNT_W = 13;
    localparam int LIM_W = 7;
    localparam int CUR_W = 14;
    localparam int ROW_W = 32;
    localparam int COL_W = 5;
    localparam int CFG_IDX_W = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_PKG_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BATCH_LIMIT = 2'd1;

    // Reset values and bounds.
    localparam logic [CNT_W-1:0] RESET_PKG_COUNT = 13'd4096;
    localparam logic [LIM_W-1:0] RESET_BATCH     = 7'd64;
    localparam logic [CNT_W-1:0] PEND_MAX        = 13'h1FFF;

    typedef enum logic [1:0] {
        REQ_MARK  = 2'd0,
        REQ_FETCH = 2'd1,
        REQ_STOP  = 2'd2,
        REQ_START = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_IDLE,
        ST_MARK,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        t_req             req_type;
        logic [CNT_W-1:0] packet_number;
    } t_in_item;

    typedef struct packed {
        logic [CNT_W-1:0] packet_number_out;
        logic             found;
        logic             last;
        logic [CNT_W-1:0] pending_count;
    } t_out_item;

endpackage

/* hw/rtl/rbs_bitmap_ram.sv */
// Bitmap storage of the retransmit bitmap scanner: one write port and one
// read port with registered read data. No package dependencies.
module rbs_bitmap_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 129,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; a read at the address being written returns the old word.
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/retransmit_bitmap_scanner.sv */
// Retransmit bitmap scanner top level: request decode, bitmap scan sequencer,
// result staging and configuration registers. Uses rbs_pkg and rbs_bitmap_ram.
//
//  Channel  | Signals                               | Payload
//  ---------+---------------------------------------+------------------------
//  request  | i_in_valid / o_in_ready               | i_in  (t_in_item)
//  result   | o_out_valid / i_out_ready             | o_out (t_out_item)
//  config   | i_cfg_valid / o_cfg_ready             | i_cfg_index, i_cfg_data
//
// Mark does one read-modify-write of a 32-bit bitmap row; stop is handled in the idle state.
// Start is followed by a fill pass over all MAX_PACKETS/32+1 bitmap rows (129 by default)
// that writes every bitmap row to ones; the same pass runs after reset.
// A fetch scans in the scan state, one packet found or one bitmap row that runs out of
// candidates at a time, and delivers the final result from the finish state.
// Results wait in an output register; a found packet stalls only while the previous one
// is held and the output register is full and not draining. The final result waits too.
module retransmit_bitmap_scanner
    import rbs_pkg::*;
#(
    parameter int MAX_PACKETS = 4096,
    parameter int MAX_BATCH   = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CNT_W-1:0]     i_cfg_data
);

    localparam int ROWS   = MAX_PACKETS / ROW_W + 1;
    localparam int ADDR_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int RIDX_W = CUR_W - COL_W;
    localparam int AX_W   = (ADDR_W > RIDX_W) ? ADDR_W : RIDX_W;

    // Row address of a bit position.
    function automatic logic [ADDR_W-1:0] row_addr(input logic [CUR_W-1:0] pos);
        logic [AX_W-1:0] wide;
        wide = AX_W'(pos[CUR_W-1:COL_W]);
        return wide[ADDR_W-1:0];
    endfunction

    // Column of the lowest set bit: isolate it, then encode the one-hot word.
    function automatic logic [COL_W-1:0] low_col(input logic [ROW_W-1:0] v);
        logic [ROW_W-1:0] iso;
        logic [COL_W-1:0] idx;
        iso = v & (~v + ROW_W'(1));
        idx = '0;
        for (int i = 0; i < ROW_W; i++) begin
            if (iso[i]) begin
                idx = idx | COL_W'(i);
            end
        end
        return idx;
    endfunction

    t_state           r_state, n_state;
    logic [ADDR_W-1:0] r_fill, n_fill;
    logic [CNT_W-1:0] r_pkg_count;
    logic [LIM_W-1:0] r_batch;
    logic [CNT_W-1:0] r_pending, n_pending;
    logic [CUR_W-1:0] r_cursor, n_cursor;
    logic             r_running, n_running;
    logic [CNT_W-1:0] r_mnum, n_mnum;
    logic [ROW_W-1:0] r_row, n_row;
    logic             r_fresh, n_fresh;
    logic [LIM_W-1:0] r_lim, n_lim;
    logic [LIM_W-1:0] r_n, n_n;
    t_out_item        r_hold, n_hold;
    logic             r_hold_valid, n_hold_valid;
    t_out_item        r_out;
    logic             r_out_valid;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ROW_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [ROW_W-1:0]  ram_rdata;

    logic             push;
    t_out_item        push_data;
    logic             can_push;
    logic [CNT_W-1:0] eff_count;
    logic [CUR_W-1:0] cnt14;
    logic [LIM_W-1:0] batch_sat;
    logic [LIM_W-1:0] lim_new;
    logic [CUR_W-1:0] cur_eff;
    logic [CNT_W-1:0] pend_dec;
    logic [CNT_W-1:0] pend_inc;
    logic [ROW_W-1:0] row_cur;
    logic [ROW_W-1:0] lo_mask;
    logic [ROW_W-1:0] hi_mask;
    logic [ROW_W-1:0] cand;
    logic [COL_W-1:0] found_col;
    logic [CUR_W-1:0] found_pos;
    logic [CUR_W-1:0] next_pos;
    logic [ROW_W-1:0] row_cleared;
    logic [ROW_W-1:0] mark_bit;
    logic [LIM_W-1:0] n_plus;

    rbs_bitmap_ram #(
        .DATA_W (ROW_W),
        .DEPTH  (ROWS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Effective register values, saturated to the build limits.
    always_comb begin
        if (32'(r_pkg_count) > MAX_PACKETS) begin
            eff_count = CNT_W'(MAX_PACKETS);
        end else begin
            eff_count = r_pkg_count;
        end
        cnt14 = CUR_W'(eff_count);
        if (r_batch > LIM_W'(MAX_BATCH)) begin
            batch_sat = LIM_W'(MAX_BATCH);
        end else begin
            batch_sat = r_batch;
        end
        if (CUR_W'(batch_sat) > cnt14) begin
            lim_new = eff_count[LIM_W-1:0];
        end else begin
            lim_new = batch_sat;
        end
        cur_eff = (r_cursor > cnt14) ? CUR_W'(1) : r_cursor;
    end

    // Pending count steps with saturation at both ends.
    assign pend_dec = (r_pending != '0) ? r_pending - CNT_W'(1) : '0;
    assign pend_inc = (r_pending != PEND_MAX) ? r_pending + CNT_W'(1) : r_pending;

    // Candidate bits of the current row: at or above the cursor, within the count.
    assign row_cur = r_fresh ? ram_rdata : r_row;
    assign lo_mask = {ROW_W{1'b1}} << r_cursor[COL_W-1:0];
    assign hi_mask = (r_cursor[CUR_W-1:COL_W] == cnt14[CUR_W-1:COL_W])
                   ? ({ROW_W{1'b1}} >> (COL_W'(ROW_W - 1) - cnt14[COL_W-1:0]))
                   : {ROW_W{1'b1}};
    assign cand        = row_cur & lo_mask & hi_mask;
    assign found_col   = low_col(cand);
    assign found_pos   = {r_cursor[CUR_W-1:COL_W], found_col};
    assign next_pos    = found_pos + CUR_W'(1);
    assign row_cleared = row_cur & ~(ROW_W'(1) << found_col);
    assign mark_bit    = ROW_W'(1) << r_mnum[COL_W-1:0];
    assign n_plus      = r_n + LIM_W'(1);
    assign can_push    = !r_out_valid || i_out_ready;

    // Sequencer: next state, memory accesses and result staging.
    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_pending    = r_pending;
        n_cursor     = r_cursor;
        n_running    = r_running;
        n_mnum       = r_mnum;
        n_row        = r_row;
        n_fresh      = r_fresh;
        n_lim        = r_lim;
        n_n          = r_n;
        n_hold       = r_hold;
        n_hold_valid = r_hold_valid;
        ram_we       = 1'b0;
        ram_waddr    = row_addr(r_cursor);
        ram_wdata    = row_cur;
        ram_raddr    = row_addr(CUR_W'(i_in.packet_number));
        push         = 1'b0;
        push_data    = r_hold;
        o_in_ready   = (r_state == ST_IDLE);

        unique case (r_state)
            ST_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = r_fill;
                ram_wdata = {ROW_W{1'b1}};
                if (r_fill == ADDR_W'(ROWS - 1)) begin
                    n_fill  = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_fill = r_fill + ADDR_W'(1);
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_in.req_type)
                        REQ_MARK: begin
                            if (r_running && i_in.packet_number != '0 &&
                                i_in.packet_number <= eff_count) begin
                                n_mnum  = i_in.packet_number;
                                n_state = ST_MARK;
                            end
                        end
                        REQ_FETCH: begin
                            if (r_running) begin
                                n_cursor = cur_eff;
                            end
                            if (r_running && lim_new != '0 && cur_eff <= cnt14) begin
                                ram_raddr = row_addr(cur_eff);
                                n_fresh   = 1'b1;
                                n_lim     = lim_new;
                                n_n       = '0;
                                n_state   = ST_SCAN;
                            end else begin
                                n_state = ST_FINISH;
                            end
                        end
                        REQ_STOP: begin
                            n_running = 1'b0;
                        end
                        REQ_START: begin
                            n_pending = eff_count;
                            n_cursor  = CUR_W'(1);
                            n_running = 1'b1;
                            n_fill    = '0;
                            n_state   = ST_FILL;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MARK: begin
                // Set the bit only if it was clear, so the count rises once.
                ram_waddr = row_addr(CUR_W'(r_mnum));
                ram_wdata = ram_rdata | mark_bit;
                if ((ram_rdata & mark_bit) == '0) begin
                    ram_we    = 1'b1;
                    n_pending = pend_inc;
                end
                n_state = ST_IDLE;
            end
            ST_SCAN: begin
                n_row   = row_cur;
                n_fresh = 1'b0;
                if (cand != '0) begin
                    if (!r_hold_valid || can_push) begin
                        // The held result is not the last one: pass it on.
                        push                    = r_hold_valid;
                        push_data               = r_hold;
                        push_data.last          = 1'b0;
                        n_hold.packet_number_out = found_pos[CNT_W-1:0];
                        n_hold.found            = 1'b1;
                        n_hold.last             = 1'b0;
                        n_hold.pending_count    = pend_dec;
                        n_hold_valid            = 1'b1;
                        n_pending               = pend_dec;
                        n_row                   = row_cleared;
                        n_n                     = n_plus;
                        n_cursor                = next_pos;
                        ram_wdata               = row_cleared;
                        if (n_plus == r_lim || next_pos > cnt14) begin
                            ram_we  = 1'b1;
                            n_state = ST_FINISH;
                        end else if (found_col == COL_W'(ROW_W - 1)) begin
                            ram_we    = 1'b1;
                            ram_raddr = row_addr(next_pos);
                            n_fresh   = 1'b1;
                        end
                    end
                end else begin
                    // Nothing left in this row: write it back and move on.
                    ram_we = 1'b1;
                    if (r_cursor[CUR_W-1:COL_W] == cnt14[CUR_W-1:COL_W]) begin
                        n_cursor = cnt14 + CUR_W'(1);
                        n_state  = ST_FINISH;
                    end else begin
                        n_cursor  = {r_cursor[CUR_W-1:COL_W] + RIDX_W'(1), COL_W'(0)};
                        ram_raddr = row_addr({r_cursor[CUR_W-1:COL_W] + RIDX_W'(1),
                                              COL_W'(0)});
                        n_fresh   = 1'b1;
                    end
                end
            end
            ST_FINISH: begin
                // Final result: the held packet, or an empty result.
                if (can_push) begin
                    push = 1'b1;
                    if (r_hold_valid) begin
                        push_data      = r_hold;
                        push_data.last = 1'b1;
                    end else begin
                        push_data.packet_number_out = '0;
                        push_data.found             = 1'b0;
                        push_data.last              = 1'b1;
                        push_data.pending_count     = r_pending;
                    end
                    n_hold_valid = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_FILL;
            r_fill       <= '0;
            r_pending    <= RESET_PKG_COUNT;
            r_cursor     <= CUR_W'(1);
            r_running    <= 1'b1;
            r_fresh      <= 1'b0;
            r_n          <= '0;
            r_hold_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_fill       <= n_fill;
            r_pending    <= n_pending;
            r_cursor     <= n_cursor;
            r_running    <= n_running;
            r_fresh      <= n_fresh;
            r_n          <= n_n;
            r_hold_valid <= n_hold_valid;
        end
    end

    // Payload registers of the sequencer.
    always_ff @(posedge i_clk) begin
        r_mnum <= n_mnum;
        r_row  <= n_row;
        r_lim  <= n_lim;
        r_hold <= n_hold;
    end

    // Output register: a result waits here until its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out <= push_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Configuration registers; writes to unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkg_count <= RESET_PKG_COUNT;
            r_batch     <= RESET_BATCH;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PKG_COUNT:   r_pkg_count <= i_cfg_data;
                CFG_BATCH_LIMIT: r_batch     <= i_cfg_data[LIM_W-1:0];
                default: begin
                    r_batch <= r_batch;
                end
            endcase
        end
    end

endmodule

/* hw/rtl/rbs_checker.sv */
// Port-level checker of the retransmit bitmap scanner and its bind statement.
// Depends on rbs_pkg and retransmit_bitmap_scanner_defines.svh.
`include "retransmit_bitmap_scanner_defines.svh"

module rbs_checker
    import rbs_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out
);

    // A stalled result keeps its valid and its payload.
    `RBS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    `RBS_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_out))

    // A found packet is never packet zero.
    `RBS_ASSERT_NOW(a_found_nonzero, i_clk, i_rst_n, o_out_valid && o_out.found, o_out.packet_number_out != '0)

    // An empty result carries packet zero and closes its fetch.
    `RBS_ASSERT_NOW(a_empty_last, i_clk, i_rst_n, o_out_valid && !o_out.found, o_out.last && o_out.packet_number_out == '0)

    // A start transfer is followed by the fill pass, which takes no request.
    `RBS_ASSERT_NEXT(a_start_fill, i_clk, i_rst_n, i_in_valid && o_in_ready && i_in.req_type == REQ_START, !o_in_ready)

endmodule

bind retransmit_bitmap_scanner rbs_checker u_rbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
